/* rtl/surf_pkg.sv */
// ============================================================================
// SURF random word generator package
// Shared constants, microcode control word and helper functions.
// ============================================================================
package surf_pkg;

   // Field and storage sizes.
   localparam int WordBits     = 32;
   localparam int ValueBits    = 16;
   localparam int SeedDepth    = 32;
   localparam int SeedAddrBits = 5;
   localparam int MixWords     = 12;
   localparam int BufWords     = 8;
   localparam int BufIdxBits   = 3;
   localparam int LeftBits     = 4;
   localparam int Rounds       = 16;
   localparam int CountBits    = 128;

   localparam logic [WordBits-1:0] GOLDEN = 32'h9e3779b9;

   // Microprogram step addresses.
   typedef logic [3:0] upc_type;
   localparam upc_type UPC_FETCH  = 4'd0;
   localparam upc_type UPC_INC    = 4'd1;
   localparam upc_type UPC_LDMIX  = 4'd2;
   localparam upc_type UPC_LDBUF  = 4'd3;
   localparam upc_type UPC_ROUND1 = 4'd4;
   localparam upc_type UPC_XOR1   = 4'd5;
   localparam upc_type UPC_ROUND2 = 4'd6;
   localparam upc_type UPC_XOR2   = 4'd7;
   localparam upc_type UPC_EMIT   = 4'd8;

   // Seed word bases for the loader steps.
   localparam logic [SeedAddrBits-1:0] BASE_KEY = 5'd0;
   localparam logic [SeedAddrBits-1:0] BASE_MIX = 5'd12;
   localparam logic [SeedAddrBits-1:0] BASE_BUF = 5'd24;

   localparam logic [3:0] LAST_MIX = 4'd11;
   localparam logic [3:0] LAST_BUF = 4'd7;

   // Datapath operations.
   typedef enum logic [2:0] {
      OP_NOP,
      OP_FETCH,
      OP_INC,
      OP_LDMIX,
      OP_LDBUF,
      OP_ROUND,
      OP_XOR,
      OP_EMIT
   } op_type;

   // Sequencer conditions.
   typedef enum logic [2:0] {
      C_NEVER,
      C_ALWAYS,
      C_NOT_DRAW,
      C_DRAW_HIT,
      C_LOOP_MORE,
      C_ROUND_MORE,
      C_RSP_BUSY
   } cond_type;

   // One control word of the microprogram.
   typedef struct packed {
      op_type                  op;
      cond_type                stay;
      cond_type                jump;
      upc_type                 target;
      logic [3:0]              lc_last;
      logic [SeedAddrBits-1:0] rd_base;
      logic                    set_full;
   } uword_type;

   // Microprogram ROM.
   function automatic uword_type ucode(upc_type upc);
      uword_type w;
      w = '{op: OP_NOP, stay: C_NEVER, jump: C_ALWAYS, target: UPC_FETCH,
            lc_last: 4'd0, rd_base: BASE_KEY, set_full: 1'b0};
      unique case (upc)
         UPC_FETCH: begin
            w.op = OP_FETCH; w.stay = C_NOT_DRAW; w.jump = C_DRAW_HIT;
            w.target = UPC_EMIT;
         end
         UPC_INC: begin
            w.op = OP_INC; w.jump = C_NEVER;
         end
         UPC_LDMIX: begin
            w.op = OP_LDMIX; w.stay = C_LOOP_MORE; w.jump = C_NEVER;
            w.lc_last = LAST_MIX; w.rd_base = BASE_MIX;
         end
         UPC_LDBUF: begin
            w.op = OP_LDBUF; w.stay = C_LOOP_MORE; w.jump = C_NEVER;
            w.lc_last = LAST_BUF; w.rd_base = BASE_BUF;
         end
         UPC_ROUND1, UPC_ROUND2: begin
            w.op = OP_ROUND; w.stay = C_ROUND_MORE; w.jump = C_NEVER;
            w.lc_last = LAST_MIX;
         end
         UPC_XOR1: begin
            w.op = OP_XOR; w.jump = C_NEVER;
         end
         UPC_XOR2: begin
            w.op = OP_XOR; w.jump = C_NEVER; w.set_full = 1'b1;
         end
         UPC_EMIT: begin
            w.op = OP_EMIT; w.stay = C_RSP_BUSY; w.jump = C_ALWAYS;
            w.target = UPC_FETCH;
         end
         default: begin
            w.op = OP_NOP;
         end
      endcase
      return w;
   endfunction

   // Rotate left by the amount that goes with the word position.
   function automatic logic [WordBits-1:0] rotl_sel(logic [WordBits-1:0] v,
                                                    logic [1:0] sel);
      logic [WordBits-1:0] r;
      case (sel)
         2'd0:    r = {v[26:0], v[31:27]};
         2'd1:    r = {v[24:0], v[31:25]};
         2'd2:    r = {v[22:0], v[31:23]};
         default: r = {v[18:0], v[31:19]};
      endcase
      return r;
   endfunction

endpackage

/* rtl/surf_ram.sv */
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ============================================================================
module surf_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/surf_random_word_generator_top.sv */
// ============================================================================
// SURF random word generator
// Microcoded sequencer that loads seed words and draws 16-bit random values.
// ============================================================================
//
//   Channel  Direction  Signals
//   req      in         req_valid, req_ready, req_kind, req_seed_index, req_seed_word
//   rsp      out        rsp_valid, rsp_ready, rsp_random_value
//
// A seed write is taken in the fetch step. A draw from a filled buffer passes from
// the fetch step straight to the emit. A draw that empties into a refill runs one
// increment, 20 seed loads, 384 mixing steps at one per cycle through the shared
// round unit, two buffer merges and the emit.
// Reset is synchronous and clears the sequencer and the seed valid bits.
// A stalled response holds the sequencer only when the next draw must emit.
//
module surf_random_word_generator_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_kind,
   input  logic [surf_pkg::SeedAddrBits-1:0]  req_seed_index,
   input  logic [surf_pkg::WordBits-1:0]      req_seed_word,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [surf_pkg::ValueBits-1:0]     rsp_random_value
);

   import surf_pkg::*;

   // Sequencer state.
   upc_type    upc_ff, upc_in;
   logic [3:0] lc_ff, lc_in;
   logic [3:0] rc_ff, rc_in;
   uword_type  uw;
   uword_type  uw_next;

   // Datapath state.
   logic [WordBits-1:0]  mix_ff [MixWords];
   logic [WordBits-1:0]  mix_in [MixWords];
   logic [WordBits-1:0]  buf_ff [BufWords];
   logic [WordBits-1:0]  buf_in [BufWords];
   logic [WordBits-1:0]  acc_ff, acc_in;
   logic [WordBits-1:0]  sum_ff, sum_in;
   logic [CountBits-1:0] count_ff, count_in;
   logic [LeftBits-1:0]  left_ff, left_in;
   logic [SeedDepth-1:0] seed_valid_ff, seed_valid_in;
   logic                 rd_valid_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [ValueBits-1:0] rsp_value_ff, rsp_value_in;

   // Seed memory port signals.
   logic                    seed_wr;
   logic [SeedAddrBits-1:0] rd_addr;
   logic [WordBits-1:0]     rd_data;
   logic [WordBits-1:0]     key;
   logic [WordBits-1:0]     cnt_word;
   logic [WordBits-1:0]     term;
   logic [WordBits-1:0]     mixed;
   logic [WordBits-1:0]     loaded;
   logic [BufIdxBits-1:0]   out_idx;

   // Condition results.
   logic lc_last_hit;
   logic rsp_busy;
   logic stay_true;
   logic jump_true;
   logic emit_fire;

   function automatic logic cond_eval(cond_type c, logic not_draw, logic draw_hit,
                                      logic loop_more, logic round_more, logic busy);
      logic r;
      unique case (c)
         C_NEVER:      r = 1'b0;
         C_ALWAYS:     r = 1'b1;
         C_NOT_DRAW:   r = not_draw;
         C_DRAW_HIT:   r = draw_hit;
         C_LOOP_MORE:  r = loop_more;
         C_ROUND_MORE: r = round_more;
         C_RSP_BUSY:   r = busy;
         default:      r = 1'b0;
      endcase
      return r;
   endfunction

   assign uw          = ucode(upc_ff);
   assign req_ready   = (uw.op == OP_FETCH);
   assign seed_wr     = req_valid && req_ready && !req_kind;
   assign lc_last_hit = (lc_ff == uw.lc_last);
   assign rsp_busy    = rsp_valid_ff && !rsp_ready;
   assign emit_fire   = (uw.op == OP_EMIT) && !rsp_busy;

   // Sequencer branch conditions.
   assign stay_true = cond_eval(uw.stay, !(req_valid && req_kind),
                                req_valid && req_kind && (left_ff != '0),
                                !lc_last_hit,
                                !lc_last_hit || (rc_ff != 4'(Rounds - 1)),
                                rsp_busy);
   assign jump_true = cond_eval(uw.jump, !(req_valid && req_kind),
                                req_valid && req_kind && (left_ff != '0),
                                !lc_last_hit,
                                !lc_last_hit || (rc_ff != 4'(Rounds - 1)),
                                rsp_busy);

   // Next step address and loop counters.
   always_comb begin
      if (stay_true) begin
         upc_in = upc_ff;
      end else if (jump_true) begin
         upc_in = uw.target;
      end else begin
         upc_in = upc_ff + 4'd1;
      end

      lc_in = lc_ff;
      rc_in = rc_ff;
      case (uw.op)
         OP_INC, OP_XOR: begin
            lc_in = '0;
         end
         OP_LDMIX, OP_LDBUF: begin
            lc_in = lc_last_hit ? 4'd0 : lc_ff + 4'd1;
         end
         OP_ROUND: begin
            lc_in = lc_last_hit ? 4'd0 : lc_ff + 4'd1;
            if (lc_last_hit) begin
               rc_in = rc_ff + 4'd1;
            end
         end
         default: begin
         end
      endcase
   end

   // The seed read is issued for the step that runs next.
   assign uw_next = ucode(upc_in);
   assign rd_addr = uw_next.rd_base + {1'b0, lc_in};

   surf_ram #(
      .WIDTH(WordBits),
      .DEPTH(SeedDepth)
   ) u_seed_ram (
      .clock   (clock),
      .wr_en   (seed_wr),
      .wr_addr (req_seed_index),
      .wr_data (req_seed_word),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Seed words never written read as zero.
   assign key = rd_valid_ff ? rd_data : '0;

   always_comb begin
      seed_valid_in = seed_valid_ff;
      if (seed_wr) begin
         seed_valid_in[req_seed_index] = 1'b1;
      end
   end

   // Counter word that enters the first four mixing words.
   always_comb begin
      if (lc_ff[3:2] == 2'd0) begin
         cnt_word = count_ff[lc_ff[1:0]*WordBits +: WordBits];
      end else begin
         cnt_word = '0;
      end
   end

   // Round unit: one mixing step per cycle.
   assign loaded  = key ^ cnt_word;
   assign term    = ((acc_ff ^ key) + sum_ff) ^ rotl_sel(acc_ff, lc_ff[1:0]);
   assign mixed   = mix_ff[0] + term;
   assign out_idx = BufIdxBits'(left_ff - 4'd1);

   // Datapath next values.
   always_comb begin
      mix_in       = mix_ff;
      buf_in       = buf_ff;
      acc_in       = acc_ff;
      sum_in       = sum_ff;
      count_in     = count_ff;
      left_in      = left_ff;
      rsp_value_in = rsp_value_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      case (uw.op)
         OP_INC: begin
            count_in = count_ff + CountBits'(1);
            sum_in   = GOLDEN;
         end
         OP_LDMIX: begin
            for (int k = 0; k < MixWords - 1; k++) begin
               mix_in[k] = mix_ff[k+1];
            end
            mix_in[MixWords-1] = loaded;
            acc_in             = loaded;
         end
         OP_LDBUF: begin
            for (int k = 0; k < BufWords - 1; k++) begin
               buf_in[k] = buf_ff[k+1];
            end
            buf_in[BufWords-1] = key;
         end
         OP_ROUND: begin
            for (int k = 0; k < MixWords - 1; k++) begin
               mix_in[k] = mix_ff[k+1];
            end
            mix_in[MixWords-1] = mixed;
            acc_in             = mixed;
            if (lc_last_hit) begin
               sum_in = sum_ff + GOLDEN;
            end
         end
         OP_XOR: begin
            for (int k = 0; k < BufWords; k++) begin
               buf_in[k] = buf_ff[k] ^ mix_ff[k+4];
            end
         end
         OP_EMIT: begin
            if (emit_fire) begin
               rsp_value_in = buf_ff[out_idx][ValueBits-1:0];
               rsp_valid_in = 1'b1;
               left_in      = left_ff - 4'd1;
            end
         end
         default: begin
         end
      endcase

      if (uw.set_full) begin
         left_in = LeftBits'(BufWords);
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff        <= UPC_FETCH;
         lc_ff         <= '0;
         rc_ff         <= '0;
         left_ff       <= '0;
         count_ff      <= '0;
         seed_valid_ff <= '0;
         rd_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         upc_ff        <= upc_in;
         lc_ff         <= lc_in;
         rc_ff         <= rc_in;
         left_ff       <= left_in;
         count_ff      <= count_in;
         seed_valid_ff <= seed_valid_in;
         rd_valid_ff   <= seed_valid_ff[rd_addr];
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      mix_ff       <= mix_in;
      buf_ff       <= buf_in;
      acc_ff       <= acc_in;
      sum_ff       <= sum_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_random_value = rsp_value_ff;

endmodule

/* rtl/surf_checker.sv */
// ============================================================================
// SURF random word generator checker
// Port-level assertions, bound to the top level.
// ============================================================================
module surf_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_ready,
   input logic                              req_kind,
   input logic [surf_pkg::SeedAddrBits-1:0] req_seed_index,
   input logic [surf_pkg::WordBits-1:0]     req_seed_word,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [surf_pkg::ValueBits-1:0]    rsp_random_value
);

   // No response is pending right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_random_value))
      else $error("stalled response changed");

   // A seed write transaction never produces a response.
   a_seed_silent: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid && req_valid && req_ready && !req_kind |=> !rsp_valid)
      else $error("seed write produced a response");

   // In the cycle after a draw transaction the block takes no request.
   a_draw_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_kind |=> !req_ready)
      else $error("request taken right after a draw");

endmodule

bind surf_random_word_generator_top surf_checker u_checker (.*);

/* sim/surf_random_word_tb_pkg.sv */
`timescale 1ns / 100ps
// ============================================================================
// SURF random word generator testbench package
// Request kind codes shared by the stimulus and the checker.
// ============================================================================
package surf_random_word_tb_pkg;

   // Request kinds carried on req_kind.
   typedef enum logic {
      KIND_SEED = 1'b0,
      KIND_DRAW = 1'b1
   } req_kind_type;

endpackage

/* sim/surf_random_word_checker.sv */
`timescale 1ns / 100ps
// ============================================================================
// SURF random word checker
// Watches the request and response channels, keeps its own copy of the seed
// words, block counter and output buffer, predicts every drawn value and
// compares each response with the oldest prediction.
// ============================================================================
module surf_random_word_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   input  logic                               req_ready,
   input  logic                               req_kind,
   input  logic [surf_pkg::SeedAddrBits-1:0]  req_seed_index,
   input  logic [surf_pkg::WordBits-1:0]      req_seed_word,
   input  logic                               rsp_valid,
   input  logic                               rsp_ready,
   input  logic [surf_pkg::ValueBits-1:0]     rsp_random_value,
   output int                                 error_count,
   output int                                 values_owed
);

   import surf_random_word_tb_pkg::*;

   localparam logic [31:0] SumStep     = 32'h9e3779b9;
   localparam int          RoundsPerPass = 16;
   localparam int          MaxReports  = 10;

   // Predicted generator state.
   logic [31:0]  seed_words [32];
   logic [127:0] block_count;
   logic [31:0]  out_block [8];
   int           words_left;

   // Drawn values not yet seen on the response channel.
   logic [15:0]  expected_values [$];
   logic [15:0]  want;
   int           errors_seen = 0;

   // Rotation amount depends on the word position within a group of four.
   function automatic logic [31:0] rotate_left(logic [31:0] v, int pos);
      int amt;
      case (pos % 4)
         0:       amt = 5;
         1:       amt = 7;
         2:       amt = 9;
         default: amt = 13;
      endcase
      return (v << amt) | (v >> (32 - amt));
   endfunction

   // Runs both mixing passes and rebuilds the eight-word output buffer.
   function automatic void refill_out_block();
      logic [31:0] mix [12];
      logic [31:0] carry;
      logic [31:0] sum;
      logic [31:0] term;
      for (int i = 0; i < 12; i++) begin
         mix[i] = (i < 4) ? block_count[32*i +: 32] : 32'h0;
         mix[i] = mix[i] ^ seed_words[12 + i];
      end
      for (int i = 0; i < 8; i++) out_block[i] = seed_words[24 + i];
      carry = mix[11];
      sum   = 32'h0;
      for (int p = 0; p < 2; p++) begin
         for (int r = 0; r < RoundsPerPass; r++) begin
            sum = sum + SumStep;
            for (int i = 0; i < 12; i++) begin
               term   = ((carry ^ seed_words[i]) + sum) ^ rotate_left(carry, i);
               mix[i] = mix[i] + term;
               carry  = mix[i];
            end
         end
         // The buffer absorbs the upper eight mixing words after each pass.
         for (int i = 0; i < 8; i++) out_block[i] = out_block[i] ^ mix[i + 4];
      end
   endfunction

   // Value returned by one draw; refills first when the buffer is empty.
   function automatic logic [15:0] next_random_value();
      if (words_left == 0) begin
         block_count = block_count + 128'd1;
         refill_out_block();
         words_left = 8;
      end
      words_left = words_left - 1;
      return out_block[words_left][15:0];
   endfunction

   function automatic void note_failure(string msg);
      if (errors_seen < MaxReports) $display("%t: %s", $realtime, msg);
      errors_seen++;
   endfunction

   // Responses are checked before requests so that a draw accepted on the same
   // edge never meets its own response.
   always @(posedge clock) begin
      if (reset) begin
         foreach (seed_words[i]) seed_words[i] = 32'h0;
         foreach (out_block[i]) out_block[i] = 32'h0;
         block_count = '0;
         words_left  = 0;
         expected_values.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_values.size() == 0) begin
               note_failure($sformatf("unexpected random_value %h with no draw pending",
                                      rsp_random_value));
            end else begin
               want = expected_values.pop_front();
               if (rsp_random_value !== want)
                  note_failure($sformatf("random_value mismatch: expected %h actual %h",
                                         want, rsp_random_value));
            end
         end
         if (req_valid && req_ready) begin
            if (req_kind == KIND_SEED) seed_words[req_seed_index] = req_seed_word;
            else expected_values.push_back(next_random_value());
         end
      end
      error_count <= errors_seen;
      values_owed <= expected_values.size();
   end

endmodule

/* sim/tb_surf_random_word_generator_top.sv */
`timescale 1ns / 100ps
// ============================================================================
// SURF random word generator testbench
// Drives seed writes and draws with random idling on both channels, checks
// every response through the checker and prints the verdict.
// ============================================================================
module tb_surf_random_word_generator_top;
   import surf_random_word_tb_pkg::*;

   localparam int CycleLimit     = 400000;
   localparam int RandomPerPhase = 209;
   localparam int SettleCycles   = 450;

   logic                               clock          = 1'b0;
   logic                               reset          = 1'b1;
   logic                               req_valid      = 1'b0;
   logic                               req_kind       = KIND_SEED;
   logic [surf_pkg::SeedAddrBits-1:0]  req_seed_index = '0;
   logic [surf_pkg::WordBits-1:0]      req_seed_word  = '0;
   logic                               rsp_ready      = 1'b0;
   logic                               req_ready;
   logic                               rsp_valid;
   logic [surf_pkg::ValueBits-1:0]     rsp_random_value;

   int error_count;
   int values_owed;
   int send_idle_pct = 0;
   int rsp_idle_pct  = 0;
   int cycle_count   = 0;

   surf_random_word_generator_top dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_seed_index   (req_seed_index),
      .req_seed_word    (req_seed_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_value (rsp_random_value)
   );

   surf_random_word_checker checker_i (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .req_seed_index   (req_seed_index),
      .req_seed_word    (req_seed_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_random_value (rsp_random_value),
      .error_count      (error_count),
      .values_owed      (values_owed)
   );

   always #5 clock = ~clock;

   // The receiver stalls at random according to the current phase.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("surf_random_word_generator_top verification failed");
         $finish;
      end
   end

   // Presents one transaction, with optional idle cycles first, and returns at
   // the edge where it is accepted.
   task automatic send_item(input req_kind_type kind,
                            input logic [surf_pkg::SeedAddrBits-1:0] idx,
                            input logic [surf_pkg::WordBits-1:0] word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_kind       <= kind;
      req_seed_index <= idx;
      req_seed_word  <= word;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Mostly draws; seed writes favor the all-zero and all-one words.
   task automatic send_random_item();
      logic [31:0] word;
      word = $urandom;
      case ($urandom_range(7))
         0:       word = 32'h0000_0000;
         1:       word = 32'hffff_ffff;
         default: ;
      endcase
      if ($urandom_range(99) < 25)
         send_item(KIND_SEED, surf_pkg::SeedAddrBits'($urandom_range(31)), word);
      else
         send_item(KIND_DRAW, surf_pkg::SeedAddrBits'($urandom_range(31)), $urandom);
   endtask

   // Holds the request channel idle until every drawn value has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (values_owed != 0) @(posedge clock);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Draws from the zero seed right after reset, across two refills.
      repeat (9) send_item(KIND_DRAW, 5'd0, 32'h0);

      // Seed writes while words remain: the buffered words still come out first.
      send_item(KIND_SEED, 5'd0,  32'hffff_ffff);
      send_item(KIND_SEED, 5'd31, 32'hffff_ffff);
      send_item(KIND_SEED, 5'd15, 32'h0000_0000);
      send_item(KIND_SEED, 5'd24, 32'h8000_0001);
      send_item(KIND_SEED, 5'd11, 32'h0000_0001);
      repeat (3) send_item(KIND_DRAW, 5'd31, 32'hffff_ffff);
      send_item(KIND_SEED, 5'd16, 32'hffff_ffff);

      // Empty the buffer so that the next refill uses the new seeds.
      repeat (5) send_item(KIND_DRAW, 5'd0, 32'h0);
      wait_for_results();

      // Random phases: receiver idles more, then sender, then neither.
      for (int p = 0; p < 3; p++) begin
         case (p)
            0: begin send_idle_pct = 30; rsp_idle_pct = 56; end
            1: begin send_idle_pct = 56; rsp_idle_pct = 30; end
            default: begin send_idle_pct = 0; rsp_idle_pct = 0; end
         endcase
         repeat (RandomPerPhase) send_random_item();
         wait_for_results();
      end

      // Let any stray response surface before the verdict.
      repeat (SettleCycles) @(posedge clock);
      if (error_count == 0 && values_owed == 0)
         $display("surf_random_word_generator_top verification clean");
      else
         $display("surf_random_word_generator_top verification failed");
      $finish;
   end

endmodule
